// ----- design/fsmatch_pkg.sv -----
// Package: word types, request codes, sizing constants and the character fold.
`default_nettype none
package fsmatch_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    typedef struct packed {
        t_req        req_type;
        logic [15:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic found;
        logic pattern_overflow;
    } t_out_word;

    typedef struct packed {
        logic go;
        t_req req;
    } t_eng_ctl;

    // case and accent folding of a raw code; 0 means "no character"
    function automatic logic [7:0] fold_code(input logic [15:0] c);
        logic [7:0] v;
        logic [7:0] r;
        v = c[7:0];
        r = 8'h00;
        if (c < 16'h0030 || c > 16'h00FC) begin
            r = 8'h00;
        end else begin
            if (v >= 8'hE0) begin
                v = v - 8'h20;
            end
            if (v >= 8'hC0) begin
                if (v <= 8'hC3) begin
                    r = 8'h41;
                end else if (v == 8'hC7) begin
                    r = 8'h43;
                end else if (v >= 8'hC8 && v <= 8'hCB) begin
                    r = 8'h45;
                end else if (v >= 8'hCC && v <= 8'hCF) begin
                    r = 8'h49;
                end else if (v >= 8'hD2 && v <= 8'hD6) begin
                    r = 8'h4F;
                end else if (v >= 8'hD9 && v <= 8'hDC) begin
                    r = 8'h55;
                end else begin
                    r = v;
                end
            end else if (v >= 8'h61 && v <= 8'h7A) begin
                r = v - 8'h20;
            end else begin
                r = v;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/fsmatch_engine.sv -----
// Pattern store and shift-and match state, updated once per executed word.
`default_nettype none
module fsmatch_engine (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  fsmatch_pkg::t_eng_ctl   i_ctl,
    input  wire [15:0]              i_code,
    output fsmatch_pkg::t_out_word  o_res
);

    logic [7:0]                          r_store [fsmatch_pkg::MAX_PATTERN];
    logic [fsmatch_pkg::LEN_W-1:0]       r_len;
    logic [fsmatch_pkg::MAX_PATTERN-1:0] r_vec;
    logic                                r_found;
    logic                                r_ovf;

    logic [7:0]                          folded;
    logic [fsmatch_pkg::MAX_PATTERN-1:0] eq;
    logic [fsmatch_pkg::MAX_PATTERN-1:0] n_vec;
    logic [fsmatch_pkg::LEN_W-1:0]       len_m1;
    logic                                hit;
    logic                                full;

    assign folded = fsmatch_pkg::fold_code(i_code);
    assign full   = (r_len == fsmatch_pkg::LEN_W'(fsmatch_pkg::MAX_PATTERN));

    always_comb begin
        for (int i = 0; i < fsmatch_pkg::MAX_PATTERN; i++) begin
            eq[i] = (fsmatch_pkg::LEN_W'(i) < r_len) && (r_store[i] != 8'h00)
                    && (r_store[i] == folded);
        end
    end

    assign n_vec  = ((r_vec << 1) | fsmatch_pkg::MAX_PATTERN'(1)) & eq;
    assign len_m1 = r_len - fsmatch_pkg::LEN_W'(1);
    assign hit    = (r_len != '0) && n_vec[len_m1[fsmatch_pkg::IDX_W-1:0]];

    // store entries carry no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.go && i_ctl.req == fsmatch_pkg::REQ_APPEND && !full) begin
            r_store[r_len[fsmatch_pkg::IDX_W-1:0]] <= folded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_vec   <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_ctl.go) begin
            case (i_ctl.req)
                fsmatch_pkg::REQ_CLEAR: begin
                    r_len   <= '0;
                    r_vec   <= '0;
                    r_found <= 1'b0;
                    r_ovf   <= 1'b0;
                end
                fsmatch_pkg::REQ_APPEND: begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= r_len + fsmatch_pkg::LEN_W'(1);
                    end
                end
                fsmatch_pkg::REQ_TEXT: begin
                    if (folded != 8'h00) begin
                        r_vec <= n_vec;
                        if (hit) begin
                            r_found <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_vec   <= '0;
                    r_found <= 1'b0;
                end
            endcase
        end
    end

    assign o_res.found            = r_found;
    assign o_res.pattern_overflow = r_ovf;

endmodule
`default_nettype wire

// ----- design/folded_substring_matcher_core.sv -----
// Top level: input register, match engine and result register with handshakes.
// A word is registered in the input stage on acceptance and executed from there; an
// end-of-text word, once executed, loads the result stage that drives o_out_valid.
// Throughput: one word per cycle, set by the single engine update per cycle; only an
// end-of-text word waits, and only while the previous result is still not taken.
// Reset (i_rst_n, synchronous, active low): empties the pattern, clears match state
// and flags and both register stages; pattern store contents are left as they are.
`default_nettype none
module folded_substring_matcher_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  fsmatch_pkg::t_in_word   i_in_word,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output fsmatch_pkg::t_out_word  o_out_word
);

    // input stage
    logic                   r_in_valid;
    fsmatch_pkg::t_in_word  r_in_word;
    // result stage
    logic                   r_out_valid;
    fsmatch_pkg::t_out_word r_out_word;

    fsmatch_pkg::t_eng_ctl  eng_ctl;
    fsmatch_pkg::t_out_word eng_res;
    logic                   is_end;
    logic                   go;

    // an end-of-text word needs room in the result stage; all others never stall
    assign is_end     = (r_in_word.req_type == fsmatch_pkg::REQ_END);
    assign go         = r_in_valid && (!is_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    assign eng_ctl.go  = go;
    assign eng_ctl.req = r_in_word.req_type;

    fsmatch_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_code  (r_in_word.char_code),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // result stage: loaded with the flags as they stand before the end word clears found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && is_end) begin
            r_out_word <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // non end-of-text words always run straight through
    a_no_stall_non_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !is_end) |-> o_in_ready)
        else $error("non end-of-text word stalled");

    // a new result only follows an executed end-of-text word
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (!$past(r_out_valid) || $past(i_out_ready)))
        |-> $past(go && is_end))
        else $error("result word without end-of-text");

    // back-pressure only when both stages are occupied
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full result stage");

endmodule
`default_nettype wire

// ----- bench/tb_folded_substring_matcher_core.sv -----
// Testbench for folded_substring_matcher_core: predicted verdicts, random streams, stalls.
module tb_folded_substring_matcher_core;
    import fsmatch_pkg::*;

    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 150;     // long receiver hold-off
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_WORDS    = 380;

    // Shift-and predictor of the containment verdict, plus the queue of verdicts owed.
    class containment_board;
        logic [7:0]             pat_sym [MAX_PATTERN];
        int unsigned            pat_len;
        logic [MAX_PATTERN-1:0] live;     // bit i: last i+1 kept chars equal pattern[0..i]
        bit                     hit;
        bit                     ovf;
        t_out_word              verdicts_due [$];
        int                     errors;
        int                     checked;
        int                     found_count;
        int                     overflows;

        function new();
            pat_len     = 0;
            live        = '0;
            hit         = 1'b0;
            ovf         = 1'b0;
            errors      = 0;
            checked     = 0;
            found_count = 0;
            overflows   = 0;
        endfunction

        // case and accent fold; 0 means the code carries no character
        function logic [7:0] fold_raw(logic [15:0] raw);
            int c;
            c = raw;
            if (c < 'h30 || c > 'hFC) begin
                return 8'h00;
            end
            if (c >= 'hE0) begin
                c = c - 'h20;
            end
            if (c >= 'hC0) begin
                if (c <= 'hC3) return 8'h41;
                if (c == 'hC7) return 8'h43;
                if (c >= 'hC8 && c <= 'hCB) return 8'h45;
                if (c >= 'hCC && c <= 'hCF) return 8'h49;
                if (c >= 'hD2 && c <= 'hD6) return 8'h4F;
                if (c >= 'hD9 && c <= 'hDC) return 8'h55;
                return 8'(c);
            end
            if (c >= 'h61 && c <= 'h7A) begin
                c = c - 'h20;
            end
            return 8'(c);
        endfunction

        function void take_word(t_in_word w);
            logic [7:0]             f;
            logic [MAX_PATTERN-1:0] eq;
            t_out_word              v;
            case (w.req_type)
                REQ_CLEAR: begin
                    pat_len = 0;
                    live    = '0;
                    hit     = 1'b0;
                    ovf     = 1'b0;
                end
                REQ_APPEND: begin
                    if (pat_len >= MAX_PATTERN) begin
                        ovf = 1'b1;
                    end else begin
                        pat_sym[pat_len] = fold_raw(w.char_code);
                        pat_len++;
                    end
                end
                REQ_TEXT: begin
                    f = fold_raw(w.char_code);
                    if (f != 8'h00) begin
                        eq = '0;
                        for (int i = 0; i < pat_len; i++) begin
                            if (pat_sym[i] != 8'h00 && pat_sym[i] == f) eq[i] = 1'b1;
                        end
                        live = ((live << 1) | 1) & eq;
                        if (pat_len > 0 && live[pat_len-1]) hit = 1'b1;
                    end
                end
                default: begin
                    v.found            = hit;
                    v.pattern_overflow = ovf;
                    verdicts_due.push_back(v);
                    live = '0;
                    hit  = 1'b0;
                end
            endcase
        endfunction

        function void check_verdict(t_out_word got);
            t_out_word want;
            checked++;
            if (verdicts_due.size() == 0) begin
                $error("result with no end-of-text word waiting: found=%0b overflow=%0b",
                       got.found, got.pattern_overflow);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0b, actual %0b", want.found, got.found);
                errors++;
            end
            if (got.pattern_overflow !== want.pattern_overflow) begin
                $error("pattern_overflow: expected %0b, actual %0b",
                       want.pattern_overflow, got.pattern_overflow);
                errors++;
            end
            if (want.found) found_count++;
            if (want.pattern_overflow) overflows++;
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    containment_board board;
    int  words_sent    = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_tok      = 1'b0;   // toggled to ask the receiver for a long hold-off

    folded_substring_matcher_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both handshakes are read just after the edge, before any NBA lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_verdict(o_out_word);
            if (i_in_valid && o_in_ready) board.take_word(i_in_word);
        end
    end

    // Receiver: random back-pressure, or a long hold-off counted here.
    initial begin
        bit hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 8);
        $error("timed out with %0d verdicts outstanding", board.verdicts_due.size());
        $display("FAIL");
        $finish;
    end

    // raw code of one of four letters A, B, C, E in a random case or accent
    function automatic logic [15:0] raw_of(int letter);
        int k;
        k = $urandom_range(9);
        case (letter)
            0: begin
                if (k == 0) return 16'h0041;
                if (k == 1) return 16'h0061;
                if (k < 6) return 16'(8'hC0 + k - 2);
                return 16'(8'hE0 + k - 6);
            end
            1: begin
                return (k < 5) ? 16'h0042 : 16'h0062;
            end
            2: begin
                case (k % 4)
                    0: return 16'h0043;
                    1: return 16'h0063;
                    2: return 16'h00C7;
                    default: return 16'h00E7;
                endcase
            end
            default: begin
                if (k == 0) return 16'h0045;
                if (k == 1) return 16'h0065;
                if (k < 6) return 16'(8'hC8 + k - 2);
                return 16'(8'hE8 + k - 6);
            end
        endcase
    endfunction

    // a code that folds to nothing
    function automatic logic [15:0] skip_code();
        if ($urandom_range(1)) return 16'($urandom_range('h2F));
        return 16'($urandom_range('hFD, 'hFFFF));
    endfunction

    function automatic logic [15:0] wide_code();
        case ($urandom_range(3))
            0: return 16'($urandom_range('hFFFF));
            1: return 16'($urandom_range('hFF));
            2: return 16'($urandom_range('h30, 'hFC));
            default: return raw_of($urandom_range(3));
        endcase
    endfunction

    task automatic send_word(t_req r, logic [15:0] code);
        t_in_word w;
        w.req_type  = r;
        w.char_code = code;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // sender pauses until every verdict owed has arrived
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // clear, build a pattern, then a few texts that often contain it
    task automatic run_sequence();
        int pat [$];
        int plen;
        int ntext;
        int tlen;
        int at;
        int letter;
        send_word(REQ_CLEAR, 16'($urandom_range('hFFFF)));
        plen = ($urandom_range(11) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 5);
        for (int k = 0; k < plen; k++) begin
            letter = ($urandom_range(19) == 0) ? -1 : $urandom_range(3);
            pat.push_back(letter);
            send_word(REQ_APPEND, (letter < 0) ? skip_code() : raw_of(letter));
        end
        ntext = $urandom_range(1, 3);
        for (int j = 0; j < ntext; j++) begin
            tlen = $urandom_range(12);
            at   = $urandom_range(1) ? $urandom_range(tlen) : -1;
            for (int k = 0; k <= tlen; k++) begin
                if (k == at) begin
                    foreach (pat[p]) begin
                        if ($urandom_range(9) == 0) send_word(REQ_TEXT, skip_code());
                        send_word(REQ_TEXT, raw_of((pat[p] < 0) ? $urandom_range(3) : pat[p]));
                    end
                end
                if (k < tlen) begin
                    case ($urandom_range(99)) inside
                        [0:11]:  send_word(REQ_TEXT, skip_code());
                        [12:14]: send_word(REQ_APPEND, raw_of($urandom_range(3)));
                        default: send_word(REQ_TEXT, raw_of($urandom_range(3)));
                    endcase
                end
            end
            send_word(REQ_END, 16'($urandom_range('hFFFF)));
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_word(t_req'($urandom_range(3)), wide_code());
    endtask

    // receiver holds off while end-of-text words keep coming, so the input stalls
    task automatic flood_while_held();
        hold_tok <= ~hold_tok;
        repeat (10) begin
            send_word(REQ_TEXT, raw_of($urandom_range(3)));
            send_word(REQ_END, 16'h0000);
        end
        settle();
    endtask

    task automatic run_phase(int s_pct, int r_pct, bit flood);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (flood) flood_while_held();
        start = words_sent;
        while (words_sent - start < PHASE_WORDS) begin
            if ($urandom_range(99) < 80) run_sequence();
            else run_noise();
            if ($urandom_range(29) == 0) settle();
        end
        settle();
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 45;
        // empty pattern never matches
        send_word(REQ_END, 16'hFFFF);
        // lower case against accented capitals
        send_word(REQ_APPEND, 16'h0061);
        send_word(REQ_APPEND, 16'h00E9);
        send_word(REQ_TEXT, 16'h00C1);
        send_word(REQ_TEXT, 16'h0045);
        send_word(REQ_END, 16'h0000);
        // skipped text codes between matching chars, range edges just outside
        send_word(REQ_TEXT, 16'h0041);
        send_word(REQ_TEXT, 16'h0000);
        send_word(REQ_TEXT, 16'hFFFF);
        send_word(REQ_TEXT, 16'h002F);
        send_word(REQ_TEXT, 16'h00FD);
        send_word(REQ_TEXT, 16'h00CB);
        send_word(REQ_END, 16'h0000);
        // a pattern char folding to zero can never match
        send_word(REQ_APPEND, 16'h0020);
        send_word(REQ_TEXT, 16'h0041);
        send_word(REQ_TEXT, 16'h0045);
        send_word(REQ_TEXT, 16'h0020);
        send_word(REQ_END, 16'h0000);
        // clear, then C-cedilla and the top code of the folded range
        send_word(REQ_CLEAR, 16'h0000);
        send_word(REQ_APPEND, 16'h00C7);
        send_word(REQ_APPEND, 16'h00FC);
        send_word(REQ_TEXT, 16'h00E7);
        send_word(REQ_TEXT, 16'h0030);
        send_word(REQ_TEXT, 16'h0055);
        send_word(REQ_END, 16'h0000);
        settle();

        run_phase(9, 45, 1'b1);
        run_phase(45, 9, 1'b0);
        run_phase(0, 0, 1'b1);

        if (board.verdicts_due.size() != 0) begin
            $error("%0d verdicts never arrived", board.verdicts_due.size());
            board.errors++;
        end
        $display("Covered %0d words in, %0d verdicts checked (%0d found, %0d with overflow),",
                 words_sent, board.checked, board.found_count, board.overflows);
        $display("under three idling mixes with long receiver hold-offs; %0d mismatches.",
                 board.errors);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/fsmatch_pkg.sv
design/fsmatch_engine.sv
design/folded_substring_matcher_core.sv
bench/tb_folded_substring_matcher_core.sv
